FILE: rtl/core/tlff_pkg.sv
// ---------------------------------------------------------------------------
// tlff_pkg: shared types and constants of the feed-forward block
// opcodes, register indexes and the fixed field widths
// ---------------------------------------------------------------------------
package tlff_pkg;

  localparam int unsigned OpW    = 3;
  localparam int unsigned IdxW   = 14;
  localparam int unsigned ValW   = 16;
  localparam int unsigned OutIdxW = 6;
  localparam int unsigned FracW  = 4;
  localparam int unsigned MwW    = 7;
  localparam int unsigned HwW    = 9;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 9;
  localparam int unsigned AccW   = 64;

  localparam logic [OpW-1:0] OP_LOAD_W1 = 3'd0;
  localparam logic [OpW-1:0] OP_LOAD_W2 = 3'd1;
  localparam logic [OpW-1:0] OP_LOAD_B1 = 3'd2;
  localparam logic [OpW-1:0] OP_LOAD_B2 = 3'd3;
  localparam logic [OpW-1:0] OP_ROW     = 3'd4;

  localparam logic [CfgIdxW-1:0] REG_FRAC_BITS    = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_MODEL_WIDTH  = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_HIDDEN_WIDTH = 2'd2;

  // one multiply-accumulate step command
  typedef struct packed {
    logic clr;    // load bias term instead of accumulating
    logic acc;    // add product
    logic fin;    // round and saturate the accumulator into the result
  } mac_ctl_t;

endpackage

FILE: rtl/core/tlff_mac.sv
// ---------------------------------------------------------------------------
// tlff_mac: shared multiply-accumulate unit
// wide accumulator, bias preload, round to nearest and saturation
// ---------------------------------------------------------------------------
module tlff_mac
  import tlff_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  mac_ctl_t               ctl_i,
  input  logic [FracW-1:0]       frac_i,
  input  logic signed [ValW-1:0] a_i,
  input  logic signed [ValW-1:0] b_i,
  output logic signed [ValW-1:0] res_o,
  output logic                   res_valid_o
);

  localparam int unsigned SatBits = (DATA_WIDTH < 16) ? DATA_WIDTH : 16;
  localparam logic signed [AccW-1:0] SatMax = (AccW'(1) <<< (SatBits - 1)) - 1;
  localparam logic signed [AccW-1:0] SatMin = -SatMax - 1;

  logic signed [2*ValW-1:0] prod_q;
  logic                     prod_v_q, clr_q, fin_p_q, fin_q;
  logic signed [ValW-1:0]   bias_q;
  logic signed [AccW-1:0]   acc_q, acc_d, rnd, shr;
  logic signed [ValW-1:0]   res_q;
  logic                     res_v_q;

  // product register, then accumulate
  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
    bias_q <= a_i;
  end

  // finish is delayed through fin_p_q and fin_q so the last product has reached the accumulator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_v_q <= 1'b0;
      clr_q    <= 1'b0;
      fin_p_q  <= 1'b0;
      fin_q    <= 1'b0;
      res_v_q  <= 1'b0;
    end else begin
      prod_v_q <= ctl_i.acc;
      clr_q    <= ctl_i.clr;
      fin_p_q  <= ctl_i.fin;
      fin_q    <= fin_p_q;
      res_v_q  <= fin_q;
    end
  end

  always_comb begin
    acc_d = acc_q;
    if (clr_q) begin
      acc_d = AccW'(bias_q) <<< frac_i;
    end else if (prod_v_q) begin
      acc_d = acc_q + AccW'(prod_q);
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  always_comb begin
    rnd = acc_q;
    if (frac_i != '0) begin
      rnd = acc_q + (AccW'(1) <<< (frac_i - 1'b1));
    end
    shr = rnd >>> frac_i;
  end

  always_ff @(posedge clk_i) begin
    if (fin_q) begin
      if (shr > SatMax) res_q <= ValW'(SatMax);
      else if (shr < SatMin) res_q <= ValW'(SatMin);
      else res_q <= ValW'(shr);
    end
  end

  assign res_o       = res_q;
  assign res_valid_o = res_v_q;

endmodule

FILE: rtl/core/two_layer_relu_feed_forward.sv
// ---------------------------------------------------------------------------
// two_layer_relu_feed_forward: position-wise feed-forward layer
// hidden = relu(row*W1+b1), out = hidden*W2+b2 in signed fixed point
// ---------------------------------------------------------------------------
// channel  direction  handshake         payload
// in       input      in_valid/stall    op, index, value
// out      output     out_valid/stall   out_value, out_index, last
// cfg      input      cfg_valid/ready   cfg_index, cfg_data
//
// loads and non-final row elements are taken whenever the block is idle
// the final row element starts a run through the one shared multiply-accumulate
// unit, which sets the rate; output stalls lengthen the run
// a result is taken one at a time; a stalled output freezes the sequencer
// reset clears control only; memories hold garbage until loaded
// ---------------------------------------------------------------------------
module two_layer_relu_feed_forward
  import tlff_pkg::*;
#(
  parameter int unsigned D_MODEL    = 64,
  parameter int unsigned D_HIDDEN   = 256,
  parameter int unsigned DATA_WIDTH = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [OpW-1:0]            op_i,
  input  logic [IdxW-1:0]           index_i,
  input  logic signed [ValW-1:0]    value_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [ValW-1:0]    out_value_o,
  output logic [OutIdxW-1:0]        out_index_o,
  output logic                      last_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CfgIdxW-1:0]        cfg_index_i,
  input  logic [CfgDatW-1:0]        cfg_data_i
);

  localparam int unsigned TabSize = D_MODEL * D_HIDDEN;
  localparam int unsigned TabAw   = (TabSize > 1) ? $clog2(TabSize) : 1;
  localparam int unsigned MAw     = (D_MODEL > 1) ? $clog2(D_MODEL) : 1;
  localparam int unsigned HAw     = (D_HIDDEN > 1) ? $clog2(D_HIDDEN) : 1;
  localparam int unsigned MCw     = $clog2(D_MODEL + 1);
  localparam int unsigned HCw     = $clog2(D_HIDDEN + 1);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_BIAS  = 6'b000010,  // read bias, preload accumulator
    ST_DOT   = 6'b000100,  // stream products
    ST_DRAIN = 6'b001000,  // wait for rounded result
    ST_EMIT  = 6'b010000,  // hand output transaction over
    ST_NEXT  = 6'b100000
  } state_e;

  // memories, all read through registered read ports
  logic signed [ValW-1:0] w1_mem [TabSize];
  logic signed [ValW-1:0] w2_mem [TabSize];
  logic signed [ValW-1:0] b1_mem [D_HIDDEN];
  logic signed [ValW-1:0] b2_mem [D_MODEL];
  logic signed [ValW-1:0] row_mem [D_MODEL];
  logic signed [ValW-1:0] hid_mem [D_HIDDEN];

  logic [FracW-1:0] frac_q;
  logic [MwW-1:0]   mw_reg_q;
  logic [HwW-1:0]   hw_reg_q;

  state_e state_q, state_d;
  logic   layer_q, layer_d;        // 0 hidden layer, 1 output layer
  logic [HCw-1:0] outer_q, outer_d; // output unit counter
  logic [HCw-1:0] inner_q, inner_d; // dot product term counter
  logic [MCw-1:0] mw;
  logic [HCw-1:0] hw, n_outer, n_inner;

  logic in_acc, out_acc;
  logic signed [ValW-1:0] w_rd_q, a_rd_q, b_rd_q, mac_res;
  logic mac_valid;
  mac_ctl_t ctl_q, ctl_d;
  logic signed [ValW-1:0] out_val_q;
  logic [OutIdxW-1:0] out_idx_q;
  logic out_last_q;

  // effective widths, zero acts as one, large values clamp
  always_comb begin
    if (mw_reg_q == '0) mw = MCw'(1);
    else if (32'(mw_reg_q) > D_MODEL) mw = MCw'(D_MODEL);
    else mw = MCw'(mw_reg_q);
    if (hw_reg_q == '0) hw = HCw'(1);
    else if (32'(hw_reg_q) > D_HIDDEN) hw = HCw'(D_HIDDEN);
    else hw = HCw'(hw_reg_q);
  end

  assign n_outer = layer_q ? HCw'(mw) : hw;
  assign n_inner = layer_q ? hw : HCw'(mw);

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_EMIT);
  assign out_acc     = out_valid_o && !out_stall_i;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frac_q   <= FracW'(12);
      mw_reg_q <= MwW'(64);
      hw_reg_q <= HwW'(256);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_FRAC_BITS:    frac_q   <= cfg_data_i[FracW-1:0];
        REG_MODEL_WIDTH:  mw_reg_q <= cfg_data_i[MwW-1:0];
        REG_HIDDEN_WIDTH: hw_reg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // load path writes
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      case (op_i)
        OP_LOAD_W1: if (32'(index_i) < TabSize) w1_mem[index_i[TabAw-1:0]] <= value_i;
        OP_LOAD_W2: if (32'(index_i) < TabSize) w2_mem[index_i[TabAw-1:0]] <= value_i;
        OP_LOAD_B1: if (32'(index_i) < D_HIDDEN) b1_mem[index_i[HAw-1:0]] <= value_i;
        OP_LOAD_B2: if (32'(index_i) < D_MODEL) b2_mem[index_i[MAw-1:0]] <= value_i;
        OP_ROW:     if (32'(index_i) < D_MODEL) row_mem[index_i[MAw-1:0]] <= value_i;
        default: ;
      endcase
    end
  end

  // read addresses for the current term
  logic [TabAw-1:0] w_addr;
  logic [HAw-1:0]   jh;
  logic [MAw-1:0]   km;
  always_comb begin
    if (layer_q) w_addr = TabAw'(32'(inner_q) * D_MODEL + 32'(outer_q));
    else         w_addr = TabAw'(32'(inner_q) * D_HIDDEN + 32'(outer_q));
    jh = HAw'(outer_q);
    km = MAw'(outer_q);
  end

  always_ff @(posedge clk_i) begin
    w_rd_q <= layer_q ? w2_mem[w_addr] : w1_mem[w_addr];
    a_rd_q <= layer_q ? hid_mem[HAw'(inner_q)] : row_mem[MAw'(inner_q)];
    b_rd_q <= layer_q ? b2_mem[km] : b1_mem[jh];
  end

  // hidden results written back with relu
  always_ff @(posedge clk_i) begin
    if (mac_valid && !layer_q) begin
      hid_mem[jh] <= mac_res[ValW-1] ? '0 : mac_res;
    end
  end

  // sequencer; the mac sees read data in the cycle after the address
  always_comb begin
    state_d = state_q;
    layer_d = layer_q;
    outer_d = outer_q;
    inner_d = inner_q;
    ctl_d   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && op_i == OP_ROW && 32'(index_i) == 32'(mw) - 1) begin
          state_d = ST_BIAS;
          layer_d = 1'b0;
          outer_d = '0;
          inner_d = '0;
        end
      end
      ST_BIAS: begin
        ctl_d.clr = 1'b1;
        state_d   = ST_DOT;
      end
      ST_DOT: begin
        ctl_d.acc = 1'b1;
        if (inner_q == n_inner - 1'b1) begin
          ctl_d.fin = 1'b1;
          state_d   = ST_DRAIN;
        end else begin
          inner_d = inner_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (mac_valid) state_d = layer_q ? ST_EMIT : ST_NEXT;
      end
      ST_EMIT: begin
        if (out_acc) state_d = ST_NEXT;
      end
      ST_NEXT: begin
        inner_d = '0;
        if (outer_q == n_outer - 1'b1) begin
          outer_d = '0;
          if (layer_q) begin
            state_d = ST_IDLE;
          end else begin
            layer_d = 1'b1;
            state_d = ST_BIAS;
          end
        end else begin
          outer_d = outer_q + 1'b1;
          state_d = ST_BIAS;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      layer_q <= 1'b0;
      outer_q <= '0;
      inner_q <= '0;
      ctl_q   <= '0;
    end else begin
      state_q <= state_d;
      layer_q <= layer_d;
      outer_q <= outer_d;
      inner_q <= inner_d;
      ctl_q   <= ctl_d;
    end
  end

  // operand mux: bias goes through the a port on the clear step
  logic signed [ValW-1:0] mac_a, mac_b;
  assign mac_a = ctl_q.clr ? b_rd_q : a_rd_q;
  assign mac_b = w_rd_q;

  tlff_mac #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl_q),
    .frac_i      (frac_q),
    .a_i         (mac_a),
    .b_i         (mac_b),
    .res_o       (mac_res),
    .res_valid_o (mac_valid)
  );

  // output holding register
  always_ff @(posedge clk_i) begin
    if (mac_valid && layer_q) begin
      out_val_q  <= mac_res;
      out_idx_q  <= OutIdxW'(outer_q);
      out_last_q <= (outer_q == n_outer - 1'b1);
    end
  end

  assign out_value_o = out_val_q;
  assign out_index_o = out_idx_q;
  assign last_o      = out_last_q;

  // output only in the second layer, mac results only while draining, stalls hold, no config while busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> layer_q) else $error("output outside second layer");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_valid |-> state_q == ST_DRAIN) else $error("mac result out of place");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && out_stall_i) |=> state_q == ST_EMIT)
    else $error("stalled result dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> !cfg_ready_o) else $error("config taken while busy");

endmodule

FILE: tb/sv/two_layer_relu_feed_forward_test.sv
// ---------------------------------------------------------------------------
// two_layer_relu_feed_forward_test: self-checking bench of the feed-forward block
// loads weights and biases, streams rows through several register settings and
// compares every output element against a fixed-point model of relu(x*W1+b1)*W2+b2
// ---------------------------------------------------------------------------
module two_layer_relu_feed_forward_test;
  import tlff_pkg::*;

  localparam int unsigned DModel  = 64;
  localparam int unsigned DHidden = 256;
  localparam int unsigned TabSize = DModel * DHidden;

  // item and result transaction shapes
  typedef struct packed {
    logic [OpW-1:0]         op;
    logic [IdxW-1:0]        idx;
    logic signed [ValW-1:0] val;
  } ff_item_t;

  typedef struct packed {
    logic signed [ValW-1:0] val;
    logic [OutIdxW-1:0]     idx;
    logic                   last;
  } ff_result_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  logic [OpW-1:0]         op_i = '0;
  logic [IdxW-1:0]        index_i = '0;
  logic signed [ValW-1:0] value_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic signed [ValW-1:0] out_value_o;
  logic [OutIdxW-1:0]     out_index_o;
  logic                   last_o;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CfgIdxW-1:0]     cfg_index_i = '0;
  logic [CfgDatW-1:0]     cfg_data_i = '0;

  two_layer_relu_feed_forward i_dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o, .op_i, .index_i, .value_i,
    .out_valid_o, .out_stall_i, .out_value_o, .out_index_o, .last_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #1 clk_i = ~clk_i;

  // items waiting for the driver, output elements the block still owes
  ff_item_t   pending_items[$];
  ff_result_t owed_outputs[$];
  int         n_errors = 0;

  // stimulus controls
  logic quiet = 1'b0;       // no idling on either side
  logic hold_req = 1'b0;    // ask the receiver for one long hold-off
  logic in_fire = 1'b0;     // an input transaction happened at the last rising edge

  // ---------------------------------------------------------------------------
  // network model: own copy of tables, buffers and registers
  // ---------------------------------------------------------------------------
  shortint       w1_tab[TabSize];
  shortint       w2_tab[TabSize];
  shortint       b1_vec[DHidden];
  shortint       b2_vec[DModel];
  shortint       row_vec[DModel];
  shortint       hid_vec[DHidden];
  logic [FracW-1:0] frac_reg = 4'd12;
  logic [MwW-1:0]   mw_reg = 7'd64;
  logic [HwW-1:0]   hw_reg = 9'd256;

  function automatic int eff_width(int w, int top);
    if (w == 0) return 1;
    return (w > top) ? top : w;
  endfunction

  // round to nearest (ties up), floor shift, saturate to 16 bits
  function automatic shortint round_sat(longint acc, int f);
    longint q;
    if (f > 0) acc += longint'(1) << (f - 1);
    q = acc >>> f;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return shortint'(q);
  endfunction

  task automatic predict_ffn(ff_item_t it);
    int         mw, hw, f;
    longint     acc;
    shortint    h;
    ff_result_t r;
    case (it.op)
      OP_LOAD_W1: w1_tab[it.idx] = it.val;
      OP_LOAD_W2: w2_tab[it.idx] = it.val;
      OP_LOAD_B1: if (it.idx < DHidden) b1_vec[it.idx] = it.val;
      OP_LOAD_B2: if (it.idx < DModel) b2_vec[it.idx] = it.val;
      OP_ROW: begin
        if (it.idx < DModel) begin
          row_vec[it.idx] = it.val;
          mw = eff_width(mw_reg, DModel);
          hw = eff_width(hw_reg, DHidden);
          f  = frac_reg;
          // only the final position of the row starts the computation
          if (it.idx == mw - 1) begin
            for (int j = 0; j < hw; j++) begin
              acc = longint'(b1_vec[j]) <<< f;
              for (int i = 0; i < mw; i++)
                acc += longint'(row_vec[i]) * longint'(w1_tab[i*DHidden + j]);
              h = round_sat(acc, f);
              hid_vec[j] = (h < 0) ? shortint'(0) : h;
            end
            for (int k = 0; k < mw; k++) begin
              acc = longint'(b2_vec[k]) <<< f;
              for (int j = 0; j < hw; j++)
                acc += longint'(hid_vec[j]) * longint'(w2_tab[j*DModel + k]);
              r.val  = round_sat(acc, f);
              r.idx  = k[OutIdxW-1:0];
              r.last = (k == mw - 1);
              owed_outputs = {owed_outputs, r};
            end
          end
        end
      end
      default: ;  // spare op codes do nothing
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // driver: presents queued items at the falling edge, idles in bursts
  // ---------------------------------------------------------------------------
  int in_gap = 0;
  always @(negedge clk_i) begin
    if (rst_ni && !(in_valid_i && !in_fire)) begin
      // previous transaction done or nothing offered
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid_i <= 1'b0;
      end else if (!quiet && pending_items.size() > 0 && $urandom_range(0, 9) == 0) begin
        in_gap <= $urandom_range(0, 14);
        in_valid_i <= 1'b0;
      end else if (pending_items.size() > 0) begin
        ff_item_t it;
        it = pending_items.pop_front();
        op_i <= it.op;
        index_i <= it.idx;
        value_i <= it.val;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver stall: random bursts plus one long hold-off once results show up
  int out_gap = 0;
  int hold_cnt = 0;
  always @(negedge clk_i) begin
    if (hold_req && hold_cnt == 0 && out_valid_o) hold_cnt <= 400;
    else if (hold_cnt > 1) hold_cnt <= hold_cnt - 1;
    if (out_gap > 0) begin
      out_gap <= out_gap - 1;
    end else if (!quiet && $urandom_range(0, 11) == 0) begin
      out_gap <= $urandom_range(1, 15);
    end
    out_stall_i <= (hold_cnt > 1) || (out_gap > 0);
  end

  // ---------------------------------------------------------------------------
  // monitor: predicts on accepted inputs, checks accepted outputs
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    in_fire <= in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o)
      predict_ffn('{op: op_i, idx: index_i, val: value_i});
    if (rst_ni && out_valid_o && !out_stall_i) begin
      ff_result_t want;
      if (owed_outputs.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("unexpected output value=%0d index=%0d last=%0b",
                   out_value_o, out_index_o, last_o);
      end else begin
        want = owed_outputs.pop_front();
        if (want.val !== out_value_o || want.idx !== out_index_o || want.last !== last_o) begin
          n_errors++;
          if (n_errors <= 10)
            $display("output mismatch: expected value=%0d index=%0d last=%0b, got %0d %0d %0b",
                     want.val, want.idx, want.last, out_value_o, out_index_o, last_o);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  task automatic write_reg(logic [CfgIdxW-1:0] ridx, int data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= ridx;
    cfg_data_i  <= data[CfgDatW-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    case (ridx)
      REG_FRAC_BITS:    frac_reg = data[FracW-1:0];
      REG_MODEL_WIDTH:  mw_reg = data[MwW-1:0];
      REG_HIDDEN_WIDTH: hw_reg = data[HwW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic signed [ValW-1:0] pick_val();
    if ($urandom_range(0, 3) == 0) return ValW'($urandom);
    return ValW'($urandom_range(0, 4095) - 2048);
  endfunction

  function automatic void add_item(logic [OpW-1:0] op, int idx, logic signed [ValW-1:0] v);
    ff_item_t it;
    it.op = op;
    it.idx = idx[IdxW-1:0];
    it.val = v;
    pending_items = {pending_items, it};
  endfunction

  // block idle: nothing queued, nothing offered, nothing owed, then a settle pause
  task automatic drain();
    do @(negedge clk_i);
    while (pending_items.size() > 0 || in_valid_i || owed_outputs.size() > 0);
    repeat (40) @(negedge clk_i);
  endtask

  // configure, fill every entry the setting reads, then send rows and noise
  task automatic run_phase(int f, int mw_set, int hw_set, int n_rows);
    int mw, hw, r;
    write_reg(REG_FRAC_BITS, f);
    write_reg(REG_MODEL_WIDTH, mw_set);
    write_reg(REG_HIDDEN_WIDTH, hw_set);
    mw = eff_width(mw_set, DModel);
    hw = eff_width(hw_set, DHidden);
    for (int i = 0; i < mw; i++)
      for (int j = 0; j < hw; j++) begin
        add_item(OP_LOAD_W1, i*DHidden + j, pick_val());
        add_item(OP_LOAD_W2, j*DModel + i, pick_val());
      end
    for (int j = 0; j < hw; j++) add_item(OP_LOAD_B1, j, pick_val());
    for (int i = 0; i < mw; i++) add_item(OP_LOAD_B2, i, pick_val());
    for (int i = 0; i < mw; i++) add_item(OP_ROW, i, pick_val());
    r = 1;
    while (r < n_rows) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          // overwrite a live weight or bias
          case ($urandom_range(0, 3))
            0: add_item(OP_LOAD_W1, $urandom_range(0, mw-1)*DHidden + $urandom_range(0, hw-1),
                        pick_val());
            1: add_item(OP_LOAD_W2, $urandom_range(0, hw-1)*DModel + $urandom_range(0, mw-1),
                        pick_val());
            2: add_item(OP_LOAD_B1, $urandom_range(0, hw-1), pick_val());
            default: add_item(OP_LOAD_B2, $urandom_range(0, mw-1), pick_val());
          endcase
        end
        2: begin
          // ignored traffic: spare ops, biases and row positions out of range
          case ($urandom_range(0, 3))
            0: add_item(OpW'(OP_ROW + $urandom_range(1, 3)), $urandom, pick_val());
            1: add_item(OP_LOAD_B1, $urandom_range(DHidden, TabSize-1), pick_val());
            2: add_item(OP_LOAD_B2, $urandom_range(DModel, TabSize-1), pick_val());
            default: add_item(OP_ROW, $urandom_range(DModel, TabSize-1), pick_val());
          endcase
        end
        default: begin
          // a row; some positions left stale, some stored beyond the width
          for (int i = 0; i < mw; i++)
            if (i == mw - 1 || $urandom_range(0, 7) != 0) add_item(OP_ROW, i, pick_val());
            else if (mw < DModel) add_item(OP_ROW, $urandom_range(mw, DModel-1), pick_val());
          r++;
        end
      endcase
    end
    drain();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (40) @(negedge clk_i);

    // zero widths act as one, max fraction
    run_phase(15, 0, 0, 3);
    // directed extremes on the same setting, saturating both layers
    add_item(OP_LOAD_B2, 0, 16'sh7fff);
    add_item(OP_LOAD_W1, 0, 16'sh8000);
    add_item(OP_LOAD_W2, 0, 16'sh7fff);
    for (int i = 0; i < 4; i++)
      add_item(OP_ROW, i, (i % 2) ? 16'sh7fff : 16'sh8000);
    add_item(OpW'(OP_ROW + 1), 16383, 16'sh7fff);
    add_item(OpW'(OP_ROW + 3), 0, 16'sh8000);
    add_item(OP_ROW, 16383, 16'sh1234);
    add_item(OP_LOAD_B1, 16383, 16'sh0001);
    add_item(OP_ROW, DModel - 1, 16'sh8000);
    add_item(OP_ROW, DModel - 1, 16'sh7fff);
    add_item(OP_ROW, 0, 16'sh7fff);
    drain();
    // a wider row with a few hidden units
    run_phase(8, 6, 3, 2);

    // small random settings; one long receiver hold-off in the middle
    for (int p = 0; p < 6; p++) begin
      if (p == 2) hold_req = 1'b1;
      if (p == 3) hold_req = 1'b0;
      if (p == 5) quiet = 1'b1;
      run_phase($urandom_range(0, 15),
                ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4),
                ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4),
                $urandom_range(2, 4));
    end

    repeat (50) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("two_layer_relu_feed_forward_test: clean");
    end else begin
      $display("two_layer_relu_feed_forward_test: errors");
    end
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("two_layer_relu_feed_forward_test: errors");
    $finish;
  end

endmodule
